/* design/scc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package scc_pkg;
  localparam int unsigned Lines = 64;
  localparam int unsigned IdxW = $clog2(Lines);
  localparam int unsigned SweepW = $clog2(2 * Lines + 1);
  localparam int unsigned HoldW = 8;
  localparam logic [31:0] EmptyTag = 32'hFFFF_FFFF;
  localparam logic [HoldW-1:0] MaxShared = 8'd127;
  localparam logic [HoldW-1:0] HoldExcl = 8'hFF;
  // Line entry: tag, holder count, accessed, dirty, loaded.
  localparam int unsigned EntW = 32 + HoldW + 3;

  typedef enum logic [2:0] {
    OpAcquire = 3'd0, OpRelease = 3'd1, OpAccess = 3'd2,
    OpZeroFill = 3'd3, OpMarkDirty = 3'd4, OpFree = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    StDone = 2'd0, StBusy = 2'd1, StNone = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SClear, SIdle, SLineRd, SLineOp, SScanRd, SScan, SSweepRd, SSweep, SOut
  } fsm_e;

  typedef struct packed {
    logic [31:0]      tag;
    logic [HoldW-1:0] hold;
    logic             acc;
    logic             dirty;
    logic             loaded;
  } entry_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] sector;
    logic        exclusive;
    logic [5:0]  line_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  granted_line;
    logic        hit;
    logic        fill_needed;
    logic        writeback_needed;
    logic [31:0] writeback_sector;
  } rsp_t;
endpackage
`default_nettype wire

/* design/scc_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface scc_req_if;
  logic valid;
  logic ready;
  scc_pkg::req_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface scc_rsp_if;
  logic valid;
  logic ready;
  scc_pkg::rsp_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

/* design/scc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module scc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* design/sector_cache_clock_replacement.sv */
`timescale 1ns / 1ps
`default_nettype none
// Tag and clock (second chance) replacement engine for a sector cache of
// scc_pkg::Lines lines. All line state sits in one single-port-write,
// registered-read RAM; only the clock hand and a small sequencer live in
// flops. After reset a clearing pass writes every line empty, during which
// no request beat is taken. Each request produces exactly one response
// beat. Line operations (release, access, zero fill, mark dirty) read the
// line, then update and write it back unless it is empty. Acquire and free
// scan the tag RAM one line per cycle for a match; an acquire that finds
// neither a match nor an empty line then runs the clock sweep, which reads
// each line and then decides and, unless it is held, writes it back,
// visiting up to 2 * Lines lines. A new request is taken once the
// previous response beat is accepted; the response is held in a register
// until then.
module sector_cache_clock_replacement (
  input wire logic clk_i,
  input wire logic rst_ni,
  scc_req_if.sink  req,
  scc_rsp_if.source rsp
);
  localparam int unsigned IW = scc_pkg::IdxW;

  scc_pkg::fsm_e state_q, state_d;
  scc_pkg::req_t req_q, req_d;
  scc_pkg::rsp_t rsp_q, rsp_d;
  logic [IW-1:0] addr_q, addr_d, hand_q, hand_d;
  logic [IW-1:0] empty_q, empty_d;
  logic empty_vld_q, empty_vld_d;
  logic [scc_pkg::SweepW-1:0] steps_q, steps_d;

  logic we;
  logic [IW-1:0] waddr, raddr;
  scc_pkg::entry_t wdata, rdata;
  logic [scc_pkg::EntW-1:0] rdata_raw;

  scc_ram #(.Width(scc_pkg::EntW), .Depth(scc_pkg::Lines)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = scc_pkg::entry_t'(rdata_raw);

  assign req.ready = (state_q == scc_pkg::SIdle);
  assign rsp.valid = (state_q == scc_pkg::SOut);
  assign rsp.payload = rsp_q;

  localparam logic [IW-1:0] LastIdx = IW'(scc_pkg::Lines - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scc_pkg::SClear;
      addr_q <= '0;
      hand_q <= '0;
      empty_vld_q <= 1'b0;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      addr_q <= addr_d;
      hand_q <= hand_d;
      empty_vld_q <= empty_vld_d;
      steps_q <= steps_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
    empty_q <= empty_d;
  end

  function automatic scc_pkg::entry_t install(logic [31:0] sec, logic excl);
    scc_pkg::entry_t e;
    e.tag = sec;
    e.hold = excl ? scc_pkg::HoldExcl : scc_pkg::HoldW'(1);
    e.acc = 1'b0;
    e.dirty = 1'b0;
    e.loaded = 1'b0;
    return e;
  endfunction

  always_comb begin
    scc_pkg::entry_t e;
    logic held;
    e = rdata;
    held = (rdata.hold != '0);
    state_d = state_q;
    req_d = req_q;
    rsp_d = rsp_q;
    addr_d = addr_q;
    hand_d = hand_q;
    empty_d = empty_q;
    empty_vld_d = empty_vld_q;
    steps_d = steps_q;
    we = 1'b0;
    waddr = addr_q;
    wdata = rdata;
    raddr = addr_q;

    case (state_q)
      scc_pkg::SClear: begin
        we = 1'b1;
        wdata = '{tag: scc_pkg::EmptyTag, hold: '0, acc: 1'b0, dirty: 1'b0, loaded: 1'b0};
        addr_d = addr_q + 1'b1;
        if (addr_q == LastIdx) begin
          state_d = scc_pkg::SIdle;
        end
      end
      scc_pkg::SIdle: begin
        rsp_d = '0;
        if (req.valid) begin
          req_d = req.payload;
          empty_vld_d = 1'b0;
          case (req.payload.operation)
            scc_pkg::OpAcquire, scc_pkg::OpFree: begin
              if (req.payload.sector == scc_pkg::EmptyTag) begin
                rsp_d.status = scc_pkg::StNone;
                state_d = scc_pkg::SOut;
              end else begin
                addr_d = '0;
                state_d = scc_pkg::SScanRd;
              end
            end
            scc_pkg::OpRelease, scc_pkg::OpAccess, scc_pkg::OpZeroFill,
            scc_pkg::OpMarkDirty: begin
              addr_d = req.payload.line_index[IW-1:0];
              state_d = scc_pkg::SLineRd;
            end
            default: begin
              rsp_d.status = scc_pkg::StNone;
              state_d = scc_pkg::SOut;
            end
          endcase
        end
      end
      scc_pkg::SLineRd: begin
        state_d = scc_pkg::SLineOp;
      end
      scc_pkg::SLineOp: begin
        state_d = scc_pkg::SOut;
        if (rdata.tag == scc_pkg::EmptyTag) begin
          rsp_d.status = scc_pkg::StNone;
        end else begin
          case (req_q.operation)
            scc_pkg::OpRelease: begin
              if (req_q.exclusive) begin
                e.hold = '0;
              end else if (!rdata.hold[scc_pkg::HoldW-1] && held) begin
                e.hold = rdata.hold - 1'b1;
              end
            end
            scc_pkg::OpAccess: begin
              if (!rdata.loaded) begin
                rsp_d.fill_needed = 1'b1;
                e.dirty = 1'b0;
                e.loaded = 1'b1;
              end
              e.acc = 1'b1;
            end
            scc_pkg::OpZeroFill: begin
              e.acc = 1'b1;
              e.dirty = 1'b1;
              e.loaded = 1'b1;
            end
            default: begin
              if (rdata.loaded) begin
                e.dirty = 1'b1;
              end
            end
          endcase
          we = 1'b1;
          wdata = e;
        end
      end
      scc_pkg::SScanRd: begin
        // Prime the read pipeline: the registered RAM output shows line addr in the next cycle.
        raddr = addr_q;
        addr_d = addr_q + 1'b1;
        state_d = scc_pkg::SScan;
      end
      scc_pkg::SScan: begin
        // rdata holds line addr_q - 1.
        raddr = addr_q;
        addr_d = addr_q + 1'b1;
        if (rdata.tag == req_q.sector) begin
          state_d = scc_pkg::SOut;
          waddr = addr_q - 1'b1;
          if (req_q.operation == scc_pkg::OpFree) begin
            if (held) begin
              rsp_d.status = scc_pkg::StBusy;
            end else begin
              we = 1'b1;
              wdata = '{tag: scc_pkg::EmptyTag, hold: '0, acc: 1'b0, dirty: 1'b0,
                        loaded: 1'b0};
            end
          end else if (req_q.exclusive) begin
            if (held) begin
              rsp_d.status = scc_pkg::StBusy;
            end else begin
              we = 1'b1;
              e.hold = scc_pkg::HoldExcl;
              wdata = e;
            end
          end else begin
            if (rdata.hold[scc_pkg::HoldW-1] || rdata.hold >= scc_pkg::MaxShared) begin
              rsp_d.status = scc_pkg::StBusy;
            end else begin
              we = 1'b1;
              e.hold = rdata.hold + 1'b1;
              wdata = e;
            end
          end
          if (rsp_d.status == scc_pkg::StDone && req_q.operation == scc_pkg::OpAcquire) begin
            rsp_d.granted_line = 6'(waddr);
            rsp_d.hit = 1'b1;
          end
        end else begin
          if (rdata.tag == scc_pkg::EmptyTag && !empty_vld_q) begin
            empty_vld_d = 1'b1;
            empty_d = addr_q - 1'b1;
          end
          if (addr_q == '0) begin
            // Last line checked without a match.
            state_d = scc_pkg::SOut;
            if (req_q.operation == scc_pkg::OpFree) begin
              rsp_d.status = scc_pkg::StNone;
            end else if (empty_vld_d) begin
              we = 1'b1;
              waddr = empty_d;
              wdata = install(req_q.sector, req_q.exclusive);
              rsp_d.granted_line = 6'(empty_d);
            end else begin
              steps_d = '0;
              state_d = scc_pkg::SSweepRd;
            end
          end
        end
      end
      scc_pkg::SSweepRd: begin
        raddr = hand_q;
        state_d = scc_pkg::SSweep;
      end
      scc_pkg::SSweep: begin
        // rdata holds line hand_q; each step reads, decides, then re-reads.
        waddr = hand_q;
        hand_d = (hand_q == LastIdx) ? '0 : hand_q + 1'b1;
        steps_d = steps_q + 1'b1;
        state_d = scc_pkg::SSweepRd;
        if (!held) begin
          if (rdata.acc) begin
            we = 1'b1;
            e.acc = 1'b0;
            wdata = e;
          end else begin
            we = 1'b1;
            wdata = install(req_q.sector, req_q.exclusive);
            rsp_d.granted_line = 6'(hand_q);
            if (rdata.loaded && rdata.dirty) begin
              rsp_d.writeback_needed = 1'b1;
              rsp_d.writeback_sector = rdata.tag;
            end
            state_d = scc_pkg::SOut;
          end
        end
        if (state_d != scc_pkg::SOut &&
            steps_d == scc_pkg::SweepW'(2 * scc_pkg::Lines)) begin
          rsp_d.status = scc_pkg::StNone;
          state_d = scc_pkg::SOut;
        end
      end
      scc_pkg::SOut: begin
        if (rsp.ready) begin
          state_d = scc_pkg::SIdle;
        end
      end
      default: begin
        state_d = scc_pkg::SIdle;
      end
    endcase
  end
endmodule
`default_nettype wire
